FILE: design/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg: shared types and codes of the contact presence tracker
// Defines action and event codes, particle stages and field widths.
// ----------------------------------------------------------------------------
package cpt_pkg;

    localparam int KEY_W       = 16;
    localparam int MAX_BODIES_DEF    = 4;
    localparam int MAX_PARTICLES_DEF = 8;

    localparam logic [1:0] ACT_CONTACT = 2'd0;
    localparam logic [1:0] ACT_SYNC    = 2'd1;
    localparam logic [1:0] ACT_CLEAR   = 2'd2;
    localparam logic [1:0] ACT_QUERY   = 2'd3;

    localparam logic [2:0] EV_ACK        = 3'd0;
    localparam logic [2:0] EV_BODY_ENTER = 3'd1;
    localparam logic [2:0] EV_BODY_EXIT  = 3'd2;
    localparam logic [2:0] EV_PART_ENTER = 3'd3;
    localparam logic [2:0] EV_PART_EXIT  = 3'd4;
    localparam logic [2:0] EV_QUERY      = 3'd5;
    localparam logic [2:0] EV_SYNC_DONE  = 3'd6;

    localparam logic [1:0] STG_NEW     = 2'd0;
    localparam logic [1:0] STG_SEEN    = 2'd1;
    localparam logic [1:0] STG_PENDING = 2'd2;

    localparam logic [0:0] REG_TRACK_BODIES    = 1'd0;
    localparam logic [0:0] REG_TRACK_PARTICLES = 1'd1;

    // one particle slot
    typedef struct packed {
        logic              used;
        logic [KEY_W-1:0]  index;
        logic [1:0]        stage;
    } part_slot_t;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic              clear;     // empty everything
        logic              touch;     // contact update (match or insert)
        logic              trk_part;
        logic [KEY_W-1:0]  bkey;
        logic [KEY_W-1:0]  pkey;
        logic              shift;     // remove selected body, pull from above
        logic              visit;     // per-particle sync step on selected cell
        logic              finish;    // close visit of selected body
    } cell_cmd_t;

endpackage

FILE: design/contact_presence_tracker.sv
// contact_presence_tracker: contact, clear and query items are accepted
// and answered with one result beat. A sync visits bodies and particle
// slots and emits result beats, the sync-done beat included; between beats
// the walk is one particle slot a cycle in the selected body cell. Output
// beats stall the walk when m_axis_tready is low.
// Synchronous active-low reset empties the table and clears both registers.
// ----------------------------------------------------------------------------
// contact_presence_tracker: body and particle presence tracker
// Chain of body cells with a controller that walks them during sync.
// ----------------------------------------------------------------------------
module contact_presence_tracker #(
    parameter int MAX_BODIES    = cpt_pkg::MAX_BODIES_DEF,
    parameter int MAX_PARTICLES = cpt_pkg::MAX_PARTICLES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [0:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // action[1:0], body_key[17:2], particle_key[33:18]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // event_res[2:0], event_body[18:3],
                                       // event_particle[34:19], overlapping[35], dropped[36]
    output logic        m_axis_tlast
);

    localparam int BW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int PW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_EMIT  = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic trk_b_reg, trk_p_reg;
    logic [BW:0] bcur_reg, bcur_next;       // body + 1
    logic [PW:0] pcur_reg, pcur_next;       // particle + 1; 0 means body step
    logic        tail_reg, tail_next;       // walk done, emit sync done
    logic        ovalid_reg, ovalid_next;
    logic [2:0]  oev_reg, oev_next;
    logic [cpt_pkg::KEY_W-1:0] obody_reg, obody_next, opart_reg, opart_next;
    logic        oov_reg, oov_next, odr_reg, odr_next, olast_reg, olast_next;
    logic        step_pending_reg, step_pending_next; // particle count loaded for the walked body

    cpt_pkg::cell_cmd_t cmd;
    logic [MAX_BODIES-1:0] used, fresh, seen, hit, phit, rfull, ins, sel, sh_in;
    logic [cpt_pkg::KEY_W-1:0] handle [MAX_BODIES];
    cpt_pkg::part_slot_t [MAX_PARTICLES-1:0] parts [MAX_BODIES];
    logic [PW:0] pcnt [MAX_BODIES];
    logic [1:0]  in_act;
    logic [cpt_pkg::KEY_W-1:0] in_bk, in_pk;
    logic        accept, any_hit, any_phit, any_full;
    logic [BW-1:0] bi;
    logic [PW-1:0] pi;
    logic [BW:0]  bcount;
    cpt_pkg::part_slot_t cur_part;

    assign in_act = s_axis_tdata[1:0];
    assign in_bk  = s_axis_tdata[17:2];
    assign in_pk  = s_axis_tdata[33:18];
    assign s_axis_tready = state_reg == ST_IDLE && !ovalid_reg;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign bi = BW'(bcur_reg - 1'b1);
    assign pi = PW'(pcur_reg - 1'b1);
    assign cur_part = parts[bi][pi];

    always_comb begin
        bcount = '0;
        for (int b = 0; b < MAX_BODIES; b++) begin
            if (used[b]) begin
                bcount = bcount + 1'b1;
            end
            ins[b] = !used[b] && (b == 0 || used[(b + MAX_BODIES - 1) % MAX_BODIES]);
            sel[b] = bcur_reg != '0 && b == int'(bi);
            sh_in[b] = bcur_reg != '0 && b >= int'(bi);
        end
        any_hit  = |hit;
        any_phit = |(hit & phit);
        any_full = |(hit & rfull);
    end

    genvar g;
    generate
        for (g = 0; g < MAX_BODIES; g++) begin : g_cell
            localparam int U = (g + 1 < MAX_BODIES) ? g + 1 : g;
            logic top;
            assign top = g + 1 >= MAX_BODIES;
            cpt_cell #(.MAX_PARTICLES(MAX_PARTICLES)) u_cell (
                .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sel(sel[g]),
                .insert_here(ins[g] && !any_hit), .shift_in(sh_in[g]),
                .up_used(top ? 1'b0 : used[U]), .up_handle(handle[U]),
                .up_fresh(fresh[U]), .up_seen(seen[U]),
                .up_parts(top ? '0 : parts[U]), .pcur(pcur_reg),
                .used(used[g]), .handle(handle[g]), .fresh(fresh[g]),
                .seen(seen[g]), .parts(parts[g]), .hit(hit[g]),
                .part_hit(phit[g]), .row_full(rfull[g]), .pcount(pcnt[g])
            );
        end
    endgenerate

    always_comb begin
        state_next = state_reg;
        bcur_next = bcur_reg;
        pcur_next = pcur_reg;
        tail_next = tail_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        oev_next = oev_reg; obody_next = obody_reg; opart_next = opart_reg;
        oov_next = oov_reg; odr_next = odr_reg; olast_next = olast_reg;
        step_pending_next = step_pending_reg;
        cmd = '0;
        cmd.bkey = in_bk;
        cmd.pkey = in_pk;
        cmd.trk_part = trk_p_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    oev_next = cpt_pkg::EV_ACK; obody_next = in_bk; opart_next = in_pk;
                    oov_next = 1'b0; odr_next = 1'b0; olast_next = 1'b1;
                    case (in_act)
                        cpt_pkg::ACT_CONTACT: begin
                            ovalid_next = 1'b1;
                            if (trk_b_reg || trk_p_reg) begin
                                cmd.touch = 1'b1;
                                odr_next = (!any_hit && bcount[BW:0] == (BW+1)'(MAX_BODIES))
                                    || (trk_p_reg && !any_phit &&
                                        (any_hit ? any_full : 1'b0));
                            end
                        end
                        cpt_pkg::ACT_CLEAR: begin
                            ovalid_next = 1'b1;
                            cmd.clear = 1'b1;
                        end
                        cpt_pkg::ACT_QUERY: begin
                            ovalid_next = 1'b1;
                            oev_next = cpt_pkg::EV_QUERY;
                            oov_next = any_phit;
                        end
                        cpt_pkg::ACT_SYNC: begin
                            bcur_next = (trk_b_reg || trk_p_reg) ? bcount : '0;
                            pcur_next = '0;
                            tail_next = 1'b0;
                            step_pending_next = 1'b0;
                            state_next = ST_WALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                obody_next = handle[bi]; opart_next = '0;
                oov_next = 1'b0; odr_next = 1'b0; olast_next = 1'b0;
                if (bcur_reg == '0) begin
                    oev_next = cpt_pkg::EV_SYNC_DONE; obody_next = '0;
                    olast_next = 1'b1; tail_next = 1'b1;
                    state_next = ST_OUT;
                end else if (!seen[bi]) begin
                    // unseen: exits for all particles from the top, then body exit
                    if (pcur_reg == '0 && !step_pending_reg) begin
                        pcur_next = pcnt[bi];
                        step_pending_next = 1'b1;
                    end else if (pcur_reg != '0) begin
                        oev_next = cpt_pkg::EV_PART_EXIT;
                        opart_next = cur_part.index;
                        pcur_next = pcur_reg - 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        oev_next = cpt_pkg::EV_BODY_EXIT;
                        cmd.shift = 1'b1;
                        bcur_next = bcur_reg - 1'b1;
                        step_pending_next = 1'b0;
                        state_next = ST_OUT;
                    end
                end else if (pcur_reg == '0 && !step_pending_reg) begin
                    pcur_next = pcnt[bi];
                    step_pending_next = 1'b1;
                    if (fresh[bi]) begin
                        oev_next = cpt_pkg::EV_BODY_ENTER;
                        state_next = ST_OUT;
                    end
                end else if (pcur_reg != '0) begin
                    cmd.visit = 1'b1;
                    pcur_next = pcur_reg - 1'b1;
                    opart_next = cur_part.index;
                    if (cur_part.stage == cpt_pkg::STG_PENDING) begin
                        oev_next = cpt_pkg::EV_PART_EXIT;
                        state_next = ST_OUT;
                    end else if (cur_part.stage == cpt_pkg::STG_NEW) begin
                        oev_next = cpt_pkg::EV_PART_ENTER;
                        state_next = ST_OUT;
                    end
                end else begin
                    cmd.finish = 1'b1;
                    bcur_next = bcur_reg - 1'b1;
                    step_pending_next = 1'b0;
                end
            end
            ST_OUT: begin
                ovalid_next = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_axis_tready) begin
                    state_next = tail_reg ? ST_IDLE : ST_WALK;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            trk_b_reg  <= 1'b0;
            trk_p_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
            bcur_reg   <= '0;
            pcur_reg   <= '0;
            tail_reg   <= 1'b0;
            step_pending_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            bcur_reg   <= bcur_next;
            pcur_reg   <= pcur_next;
            tail_reg   <= tail_next;
            step_pending_reg <= step_pending_next;
            if (cfg_we && cfg_addr == cpt_pkg::REG_TRACK_BODIES) begin
                trk_b_reg <= cfg_wdata[0];
            end
            if (cfg_we && cfg_addr == cpt_pkg::REG_TRACK_PARTICLES) begin
                trk_p_reg <= cfg_wdata[0];
            end
        end
        oev_reg <= oev_next; obody_reg <= obody_next; opart_reg <= opart_next;
        oov_reg <= oov_next; odr_reg <= odr_next; olast_reg <= olast_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {3'b0, odr_reg, oov_reg, opart_reg, obody_reg, oev_reg};
    assign m_axis_tlast  = olast_reg;

endmodule

FILE: design/cpt_cell.sv
// ----------------------------------------------------------------------------
// cpt_cell: one body slot with its packed particle row
// Matches contacts in parallel, and steps its particles during a sync walk.
// ----------------------------------------------------------------------------
module cpt_cell #(
    parameter int MAX_PARTICLES = cpt_pkg::MAX_PARTICLES_DEF,
    parameter int PW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cpt_pkg::cell_cmd_t           cmd,
    input  logic                         sel,         // this cell is walked
    input  logic                         insert_here, // first free slot
    input  logic                         shift_in,    // take neighbor contents
    input  logic                         up_used,
    input  logic [cpt_pkg::KEY_W-1:0]    up_handle,
    input  logic                         up_fresh,
    input  logic                         up_seen,
    input  cpt_pkg::part_slot_t [MAX_PARTICLES-1:0] up_parts,
    input  logic [PW:0]                  pcur,        // walk position + 1
    output logic                         used,
    output logic [cpt_pkg::KEY_W-1:0]    handle,
    output logic                         fresh,
    output logic                         seen,
    output cpt_pkg::part_slot_t [MAX_PARTICLES-1:0] parts,
    output logic                         hit,
    output logic                         part_hit,
    output logic                         row_full,
    output logic [PW:0]                  pcount
);

    logic                   used_reg, used_next;
    logic [cpt_pkg::KEY_W-1:0] handle_reg, handle_next;
    logic                   fresh_reg, fresh_next, seen_reg, seen_next;
    cpt_pkg::part_slot_t [MAX_PARTICLES-1:0] parts_reg, parts_next;
    logic [MAX_PARTICLES-1:0] pmatch;
    logic [PW-1:0]          pidx;

    assign used   = used_reg;
    assign handle = handle_reg;
    assign fresh  = fresh_reg;
    assign seen   = seen_reg;
    assign parts  = parts_reg;
    assign hit    = used_reg && handle_reg == cmd.bkey;
    assign pidx   = PW'(pcur - 1'b1);

    always_comb begin
        pcount = '0;
        for (int p = 0; p < MAX_PARTICLES; p++) begin
            pmatch[p] = parts_reg[p].used && parts_reg[p].index == cmd.pkey;
            if (parts_reg[p].used) begin
                pcount = pcount + 1'b1;
            end
        end
    end
    assign part_hit = |pmatch;
    assign row_full = parts_reg[MAX_PARTICLES-1].used;

    always_comb begin
        used_next   = used_reg;
        handle_next = handle_reg;
        fresh_next  = fresh_reg;
        seen_next   = seen_reg;
        parts_next  = parts_reg;
        if (cmd.clear) begin
            used_next = 1'b0;
            for (int p = 0; p < MAX_PARTICLES; p++) begin
                parts_next[p].used = 1'b0;
            end
        end else if (cmd.shift && shift_in) begin
            used_next   = up_used;
            handle_next = up_handle;
            fresh_next  = up_fresh;
            seen_next   = up_seen;
            parts_next  = up_parts;
        end else if (cmd.touch && (hit || insert_here)) begin
            if (insert_here) begin
                used_next   = 1'b1;
                handle_next = cmd.bkey;
                fresh_next  = 1'b1;
                for (int p = 0; p < MAX_PARTICLES; p++) begin
                    parts_next[p].used = 1'b0;
                end
            end
            seen_next = 1'b1;
            if (cmd.trk_part) begin
                if (hit && part_hit) begin
                    for (int p = 0; p < MAX_PARTICLES; p++) begin
                        if (pmatch[p]) begin
                            parts_next[p].stage = cpt_pkg::STG_SEEN;
                        end
                    end
                end else if (insert_here) begin
                    parts_next[0].used  = 1'b1;
                    parts_next[0].index = cmd.pkey;
                    parts_next[0].stage = cpt_pkg::STG_NEW;
                end else if (!row_full) begin
                    parts_next[pcount[PW-1:0]].used  = 1'b1;
                    parts_next[pcount[PW-1:0]].index = cmd.pkey;
                    parts_next[pcount[PW-1:0]].stage = cpt_pkg::STG_NEW;
                end
            end
        end else if (sel && cmd.finish) begin
            fresh_next = 1'b0;
            seen_next  = 1'b0;
        end else if (sel && cmd.visit && seen_reg) begin
            // particles above the walked slot slide down one place on removal
            if (parts_reg[pidx].stage == cpt_pkg::STG_PENDING) begin
                for (int p = 0; p < MAX_PARTICLES; p++) begin
                    if (p >= int'(pidx)) begin
                        if (p + 1 < MAX_PARTICLES) begin
                            parts_next[p] = parts_reg[(p + 1) % MAX_PARTICLES];
                        end else begin
                            parts_next[p].used = 1'b0;
                        end
                    end
                end
            end else begin
                parts_next[pidx].stage = cpt_pkg::STG_PENDING;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
            for (int p = 0; p < MAX_PARTICLES; p++) begin
                parts_reg[p].used <= 1'b0;
            end
        end else begin
            used_reg <= used_next;
            for (int p = 0; p < MAX_PARTICLES; p++) begin
                parts_reg[p].used <= parts_next[p].used;
            end
        end
        handle_reg <= handle_next;
        fresh_reg  <= fresh_next;
        seen_reg   <= seen_next;
        for (int p = 0; p < MAX_PARTICLES; p++) begin
            parts_reg[p].index <= parts_next[p].index;
            parts_reg[p].stage <= parts_next[p].stage;
        end
    end

endmodule
